/* design/ltfs_pkg.sv */
`default_nettype none

package ltfs_pkg;

	localparam int LIGHT_COUNT_DEF = 8;
	localparam int LIGHT_MAX       = 8;
	localparam int CHAN_N          = 3;
	localparam int APB_ADDR_W      = 5;
	localparam int APB_DATA_W      = 32;

	typedef enum logic [2:0] {
		REG_AMBIENT_RED   = 3'd0,
		REG_AMBIENT_GREEN = 3'd1,
		REG_AMBIENT_BLUE  = 3'd2,
		REG_DEPTH_TEST    = 3'd3,
		REG_DEPTH_WRITE   = 3'd4
	} reg_idx_t;

endpackage

`default_nettype wire

/* design/lit_texture_fragment_shader.sv */
`default_nettype none

// Channel   Ports                                             Handshake
// fragment  texel_word shade_* light_levels *_depth           start / busy
// result    pixel_write pixel_* depth_write depth_out         done (one cycle)
// config    paddr pwdata prdata                               psel penable pwrite pready
//
// Four register stages: texel*shade, per-light multiply, term sum, clamp/gate.
// One fragment per clock; each result moves through these stages in order and is shown with done.
// busy is never raised and the pipeline never stalls: the result side
// cannot hold off a transfer.
// arst_n clears valid bits and config registers; data registers are not reset.
module lit_texture_fragment_shader
	import ltfs_pkg::*;
#(
	parameter int LIGHT_COUNT = LIGHT_COUNT_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [31:0]           texel_word,
	input  wire logic [7:0]            shade_red,
	input  wire logic [7:0]            shade_green,
	input  wire logic [7:0]            shade_blue,
	input  wire logic [63:0]           light_levels,
	input  wire logic [15:0]           fragment_depth,
	input  wire logic [15:0]           stored_depth,
	output logic                       done,
	output logic                       pixel_write,
	output logic [7:0]                 pixel_red,
	output logic [7:0]                 pixel_green,
	output logic [7:0]                 pixel_blue,
	output logic                       depth_write,
	output logic [15:0]                depth_out,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0]      prdata,
	output logic                       pready
);

	localparam int TERM_N = LIGHT_COUNT + 1;
	localparam int SUM_W  = $clog2(TERM_N * 255 + 1);
	localparam int LVL_W  = 8 * LIGHT_COUNT;

	// config registers
	logic [7:0] ambient_q [CHAN_N];
	logic       depth_test_q;
	logic       depth_write_q;
	reg_idx_t   reg_idx;
	logic       cfg_wr;

	assign pready  = 1'b1;
	assign busy    = 1'b0;
	assign reg_idx = reg_idx_t'(paddr[4:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ambient_q[0]  <= '0;
			ambient_q[1]  <= '0;
			ambient_q[2]  <= '0;
			depth_test_q  <= 1'b0;
			depth_write_q <= 1'b0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_AMBIENT_RED:   ambient_q[0]  <= pwdata[7:0];
				REG_AMBIENT_GREEN: ambient_q[1]  <= pwdata[7:0];
				REG_AMBIENT_BLUE:  ambient_q[2]  <= pwdata[7:0];
				REG_DEPTH_TEST:    depth_test_q  <= pwdata[0];
				REG_DEPTH_WRITE:   depth_write_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_AMBIENT_RED:   prdata = APB_DATA_W'(ambient_q[0]);
			REG_AMBIENT_GREEN: prdata = APB_DATA_W'(ambient_q[1]);
			REG_AMBIENT_BLUE:  prdata = APB_DATA_W'(ambient_q[2]);
			REG_DEPTH_TEST:    prdata = APB_DATA_W'(depth_test_q);
			REG_DEPTH_WRITE:   prdata = APB_DATA_W'(depth_write_q);
			default:           prdata = '0;
		endcase
	end

	// pipeline
	logic              accept;
	logic              v_s1, v_s2, v_s3;
	logic [15:0]       ts_s1 [CHAN_N];
	logic [LVL_W-1:0]  lvl_s1;
	logic              pass_s1, pass_s2, pass_s3;
	logic [15:0]       depth_s1, depth_s2, depth_s3;
	logic [7:0]        term_s2 [CHAN_N][TERM_N];
	logic [SUM_W-1:0]  sum_s3 [CHAN_N];
	logic [7:0]        texel_b [CHAN_N];
	logic [7:0]        shade_b [CHAN_N];
	logic [23:0]       prod [CHAN_N][TERM_N];
	logic [SUM_W-1:0]  sum_c [CHAN_N];
	logic [7:0]        clamp_c [CHAN_N];
	logic              done_q;
	logic              pixel_write_q, depth_write_out_q;
	logic [7:0]        pix_q [CHAN_N];
	logic [15:0]       depth_out_q;

	assign accept     = start && !busy;
	assign texel_b[0] = texel_word[31:24];
	assign texel_b[1] = texel_word[23:16];
	assign texel_b[2] = texel_word[15:8];
	assign shade_b[0] = shade_red;
	assign shade_b[1] = shade_green;
	assign shade_b[2] = shade_blue;

	always_comb begin
		for (int c = 0; c < CHAN_N; c++) begin
			prod[c][0] = 24'(ts_s1[c]) * 24'(ambient_q[c]);
			for (int k = 0; k < LIGHT_COUNT; k++) begin
				prod[c][k+1] = 24'(ts_s1[c]) * 24'(lvl_s1[8*k +: 8]);
			end
		end
	end

	always_comb begin
		for (int c = 0; c < CHAN_N; c++) begin
			sum_c[c] = '0;
			for (int k = 0; k < TERM_N; k++) begin
				sum_c[c] = sum_c[c] + SUM_W'(term_s2[c][k]);
			end
			clamp_c[c] = (sum_s3[c] > SUM_W'(255)) ? 8'hFF : sum_s3[c][7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= accept;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			done_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int c = 0; c < CHAN_N; c++) begin
				ts_s1[c] <= 16'(texel_b[c]) * 16'(shade_b[c]);
			end
			lvl_s1   <= light_levels[LVL_W-1:0];
			pass_s1  <= !depth_test_q || (stored_depth >= fragment_depth);
			depth_s1 <= fragment_depth;
		end
		if (v_s1) begin
			for (int c = 0; c < CHAN_N; c++) begin
				for (int k = 0; k < TERM_N; k++) begin
					term_s2[c][k] <= prod[c][k][23:16];
				end
			end
			pass_s2  <= pass_s1;
			depth_s2 <= depth_s1;
		end
		if (v_s2) begin
			for (int c = 0; c < CHAN_N; c++) begin
				sum_s3[c] <= sum_c[c];
			end
			pass_s3  <= pass_s2;
			depth_s3 <= depth_s2;
		end
		if (v_s3) begin
			for (int c = 0; c < CHAN_N; c++) begin
				pix_q[c] <= pass_s3 ? clamp_c[c] : 8'h00;
			end
			pixel_write_q     <= pass_s3;
			depth_write_out_q <= pass_s3 && depth_write_q;
			depth_out_q       <= depth_s3;
		end
	end

	assign done        = done_q;
	assign pixel_write = pixel_write_q;
	assign pixel_red   = pix_q[0];
	assign pixel_green = pix_q[1];
	assign pixel_blue  = pix_q[2];
	assign depth_write = depth_write_out_q;
	assign depth_out   = depth_out_q;

`ifndef ASSERT_OFF
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##4 done)
		else $error("result transfer missing four cycles after start");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !pixel_write) |->
			(pixel_red == 8'h00 && pixel_green == 8'h00 && pixel_blue == 8'h00
			 && !depth_write))
		else $error("failed fragment carries color or depth write");

	a_dw_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(done && depth_write) |-> pixel_write)
		else $error("depth write without pixel write");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> depth_out == $past(fragment_depth, 4))
		else $error("depth_out does not match fragment depth");
`endif

endmodule

`default_nettype wire
